>>> src/tpps_pkg.sv
// Shared widths, register codes, constants, the arctangent table and the stage-boundary types.
package tpps_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_TARGET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_TARGET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_TARGET_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REAR_TARGET_Y = 2'd3;

    localparam int DIFF_W      = 33;  // difference of two Q16.16 words
    localparam int OPR_W       = 32;  // prescaled operand, magnitude at most 2^30
    localparam int PROD_W      = 64;
    localparam int NUM_W       = 63;  // numerators, magnitude at most 2^61
    localparam int MAG_W       = NUM_W;
    localparam int DEN_W       = 62;  // denominator, at most 2^61
    localparam int K_W         = 5;   // fractional shift of the quotient, 14..18
    localparam int QUO_W       = 31;  // quotient bits below the saturation limit
    localparam int NORM_STAGES = 31;  // one-bit normalising shifts ahead of the rotator
    localparam int CX_W        = 34;  // rotator vector width, covers the CORDIC gain
    localparam int Z_W         = 21;  // angle accumulator, Q.16 radians
    localparam int ANG_W       = 16;  // Q2.13 radians

    localparam logic signed [Z_W-1:0]   PI_Q16 = 21'sd205887;
    localparam logic signed [ANG_W-1:0] PI_Q13 = 16'sd25736;
    localparam logic signed [31:0]      LIM31  = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                    valid;
        logic                    degen;
        logic [K_W-1:0]          k;
        logic [DEN_W-1:0]        den;
        logic signed [NUM_W-1:0] nc;
        logic signed [NUM_W-1:0] nd;
        logic signed [31:0]      rx;
        logic signed [31:0]      ry;
    } front_out_t;

    typedef struct packed {
        logic               valid;
        logic               degen;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
    } quot_t;

    typedef struct packed {
        logic               valid;
        logic               degen;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
    } pose_t;

    typedef struct packed {
        logic                    valid;
        logic signed [ANG_W-1:0] angle;
    } angle_t;

    // Arctangent of 2^-i in Q.16 radians, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        unique case (i)
            0:       return 21'sd51472;
            1:       return 21'sd30386;
            2:       return 21'sd16055;
            3:       return 21'sd8150;
            4:       return 21'sd4091;
            5:       return 21'sd2047;
            6:       return 21'sd1024;
            7:       return 21'sd512;
            8:       return 21'sd256;
            9:       return 21'sd128;
            10:      return 21'sd64;
            11:      return 21'sd32;
            12:      return 21'sd16;
            13:      return 21'sd8;
            14:      return 21'sd4;
            15:      return 21'sd2;
            16:      return 21'sd1;
            default: return 21'sd0;
        endcase
    endfunction

endpackage

>>> src/tpps_front.sv
// Front end: differences, prescale, products and the numerator/denominator sums.
module tpps_front
    import tpps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] side_x,
    input  logic signed [31:0] side_y,
    input  logic signed [31:0] rear_x,
    input  logic signed [31:0] rear_y,
    input  logic signed [31:0] side_tx,
    input  logic signed [31:0] side_ty,
    input  logic signed [31:0] rear_tx,
    input  logic signed [31:0] rear_ty,
    output front_out_t         fo
);

    localparam logic [DIFF_W-1:0] FIT_LIM = DIFF_W'(1073741824);

    function automatic logic [DIFF_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? -v : v;
    endfunction

    function automatic logic [1:0] fit_shift(input logic signed [DIFF_W-1:0] u,
                                             input logic signed [DIFF_W-1:0] w);
        logic [DIFF_W-1:0] mu;
        logic [DIFF_W-1:0] mw;
        mu = mag_of(u);
        mw = mag_of(w);
        if ((mu >> 1) > FIT_LIM || (mw >> 1) > FIT_LIM) begin
            return 2'd2;
        end
        if (mu > FIT_LIM || mw > FIT_LIM) begin
            return 2'd1;
        end
        return 2'd0;
    endfunction

    // Shift toward zero
    function automatic logic signed [OPR_W-1:0] shr_tz(input logic signed [DIFF_W-1:0] v,
                                                       input logic [1:0] n);
        logic [DIFF_W-1:0] m;
        m = mag_of(v) >> n;
        return v[DIFF_W-1] ? -OPR_W'(m) : OPR_W'(m);
    endfunction

    // Stage 1
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, tx1_reg, ty1_reg;
    logic signed [31:0]       rx1_reg, ry1_reg;
    // Stage 2
    logic                     v2_reg, degen2_reg;
    logic signed [OPR_W-1:0]  a2_reg, b2_reg, p2_reg, q2_reg;
    logic [K_W-1:0]           k2_reg;
    logic signed [31:0]       rx2_reg, ry2_reg;
    // Stage 3
    logic                     v3_reg, degen3_reg;
    logic signed [PROD_W-1:0] aa3_reg, bb3_reg, qa3_reg, pb3_reg, pa3_reg, qb3_reg;
    logic [K_W-1:0]           k3_reg;
    logic signed [31:0]       rx3_reg, ry3_reg;
    // Stage 4
    front_out_t               fo_reg;

    logic [1:0] sh_d, sh_t;

    assign sh_d = fit_shift(dx1_reg, dy1_reg);
    assign sh_t = fit_shift(tx1_reg, ty1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg <= DIFF_W'(rear_x) - DIFF_W'(side_x);
        dy1_reg <= DIFF_W'(rear_y) - DIFF_W'(side_y);
        tx1_reg <= DIFF_W'(rear_tx) - DIFF_W'(side_tx);
        ty1_reg <= DIFF_W'(rear_ty) - DIFF_W'(side_ty);
        rx1_reg <= rear_x;
        ry1_reg <= rear_y;

        degen2_reg <= (dx1_reg == '0) && (dy1_reg == '0);
        a2_reg     <= shr_tz(dx1_reg, sh_d);
        b2_reg     <= shr_tz(dy1_reg, sh_d);
        p2_reg     <= shr_tz(tx1_reg, sh_t);
        q2_reg     <= shr_tz(ty1_reg, sh_t);
        k2_reg     <= K_W'(16) + K_W'(sh_t) - K_W'(sh_d);
        rx2_reg    <= rx1_reg;
        ry2_reg    <= ry1_reg;

        degen3_reg <= degen2_reg;
        aa3_reg    <= a2_reg * a2_reg;
        bb3_reg    <= b2_reg * b2_reg;
        qa3_reg    <= q2_reg * a2_reg;
        pb3_reg    <= p2_reg * b2_reg;
        pa3_reg    <= p2_reg * a2_reg;
        qb3_reg    <= q2_reg * b2_reg;
        k3_reg     <= k2_reg;
        rx3_reg    <= rx2_reg;
        ry3_reg    <= ry2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fo_reg <= '0;
        end
        else
        begin
            fo_reg.valid <= v3_reg;
            fo_reg.degen <= degen3_reg;
            fo_reg.k     <= k3_reg;
            fo_reg.den   <= DEN_W'(aa3_reg + bb3_reg);
            fo_reg.nc    <= NUM_W'(qa3_reg - pb3_reg);
            fo_reg.nd    <= NUM_W'(pa3_reg + qb3_reg);
            fo_reg.rx    <= rx3_reg;
            fo_reg.ry    <= ry3_reg;
        end
    end

    assign fo = fo_reg;

endmodule

>>> src/tpps_divider.sv
// Two-lane pipelined restoring divider for the sine and cosine terms, one quotient bit a stage.
module tpps_divider
    import tpps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  front_out_t fi,
    output quot_t      qo
);

    localparam int SH_MAX = 17;
    localparam int CMP_W  = DEN_W + SH_MAX;

    logic               vld_reg   [QUO_W+1];
    logic               degen_reg [QUO_W+1];
    logic [DEN_W-1:0]   den_reg   [QUO_W+1];
    logic signed [31:0] rx_reg    [QUO_W+1];
    logic signed [31:0] ry_reg    [QUO_W+1];

    logic [DEN_W-1:0]   rem_reg [2][QUO_W+1];
    logic [QUO_W-1:0]   low_reg [2][QUO_W+1];
    logic [QUO_W-1:0]   quo_reg [2][QUO_W+1];
    logic               sat_reg [2][QUO_W+1];
    logic               neg_reg [2][QUO_W+1];

    logic signed [31:0] res [2];
    quot_t              qo_reg;

    // Shared control and side data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= QUO_W; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= fi.valid;
            for (int j = 1; j <= QUO_W; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        degen_reg[0] <= fi.degen;
        den_reg[0]   <= fi.den;
        rx_reg[0]    <= fi.rx;
        ry_reg[0]    <= fi.ry;
        for (int j = 1; j <= QUO_W; j++)
        begin
            degen_reg[j] <= degen_reg[j-1];
            den_reg[j]   <= den_reg[j-1];
            rx_reg[j]    <= rx_reg[j-1];
            ry_reg[j]    <= ry_reg[j-1];
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [NUM_W-1:0] num;
        logic [MAG_W-1:0]        mag;
        logic [K_W-1:0]          sh;
        logic                    sat;

        assign num = (l == 0) ? fi.nc : fi.nd;
        assign mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        assign sh  = K_W'(QUO_W) - fi.k;
        // Quotient reaches 2^31 exactly when mag >= den * 2^(31-k)
        assign sat = CMP_W'(mag) >= (CMP_W'(fi.den) << sh);

        always_ff @(posedge clk)
        begin
            rem_reg[l][0] <= DEN_W'(mag >> sh);
            low_reg[l][0] <= QUO_W'(mag << fi.k);
            quo_reg[l][0] <= '0;
            sat_reg[l][0] <= sat;
            neg_reg[l][0] <= num[NUM_W-1];
        end

        for (genvar j = 1; j <= QUO_W; j++)
        begin : g_step
            logic [DEN_W:0] trial;
            logic           ge;

            assign trial = {rem_reg[l][j-1], low_reg[l][j-1][QUO_W-1]};
            assign ge    = trial >= {1'b0, den_reg[j-1]};

            always_ff @(posedge clk)
            begin
                rem_reg[l][j] <= ge ? DEN_W'(trial - {1'b0, den_reg[j-1]}) : DEN_W'(trial);
                low_reg[l][j] <= low_reg[l][j-1] << 1;
                quo_reg[l][j] <= {quo_reg[l][j-1][QUO_W-2:0], ge};
                sat_reg[l][j] <= sat_reg[l][j-1];
                neg_reg[l][j] <= neg_reg[l][j-1];
            end
        end

        // Apply saturation and sign
        always_comb
        begin
            if (sat_reg[l][QUO_W])
            begin
                res[l] = neg_reg[l][QUO_W] ? -LIM31 : LIM31;
            end
            else
            begin
                res[l] = neg_reg[l][QUO_W] ? -$signed({1'b0, quo_reg[l][QUO_W]})
                                           : $signed({1'b0, quo_reg[l][QUO_W]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qo_reg <= '0;
        end
        else
        begin
            qo_reg.valid <= vld_reg[QUO_W];
            qo_reg.degen <= degen_reg[QUO_W];
            qo_reg.c     <= res[0];
            qo_reg.d     <= res[1];
            qo_reg.rx    <= rx_reg[QUO_W];
            qo_reg.ry    <= ry_reg[QUO_W];
        end
    end

    assign qo = qo_reg;

endmodule

>>> src/tpps_pose.sv
// Back-substitution of the solved terms into robot x and y, with saturation.
module tpps_pose
    import tpps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  quot_t              qi,
    input  logic signed [31:0] rear_tx,
    input  logic signed [31:0] rear_ty,
    output pose_t              po
);

    localparam int SUM_W  = PROD_W + 1;
    localparam int PSUM_W = 50;
    localparam logic signed [PSUM_W-1:0] POS_LIM = PSUM_W'(LIM31);
    localparam logic signed [PSUM_W-1:0] NEG_LIM = ~POS_LIM;

    function automatic logic signed [31:0] sat32(input logic signed [PSUM_W-1:0] v);
        if (v > POS_LIM) begin
            return LIM31;
        end
        if (v < NEG_LIM) begin
            return ~LIM31;
        end
        return v[31:0];
    endfunction

    logic                     v1_reg, degen1_reg;
    logic signed [PROD_W-1:0] cry_reg, drx_reg, crx_reg, dry_reg;
    pose_t                    po_reg;

    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [PSUM_W-1:0] px_full, py_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= qi.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        degen1_reg <= qi.degen;
        cry_reg    <= qi.c * qi.ry;
        drx_reg    <= qi.d * qi.rx;
        crx_reg    <= qi.c * qi.rx;
        dry_reg    <= qi.d * qi.ry;
    end

    // Floor shift of the product sums, then offset by the rear target
    assign sum_x   = SUM_W'(cry_reg) - SUM_W'(drx_reg);
    assign sum_y   = -SUM_W'(crx_reg) - SUM_W'(dry_reg);
    assign px_full = PSUM_W'(sum_x >>> 16) + PSUM_W'(rear_tx);
    assign py_full = PSUM_W'(sum_y >>> 16) + PSUM_W'(rear_ty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            po_reg <= '0;
        end
        else
        begin
            po_reg.valid  <= v1_reg;
            po_reg.degen  <= degen1_reg;
            po_reg.pose_x <= sat32(px_full);
            po_reg.pose_y <= sat32(py_full);
        end
    end

    assign po = po_reg;

endmodule

>>> src/tpps_cordic.sv
// Pipelined vectoring CORDIC: normalising shifts, half-plane fold, rotations, rounding.
module tpps_cordic
    import tpps_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  front_out_t fi,
    output angle_t     ao
);

    localparam logic signed [NUM_W-1:0] NORM_LIM = NUM_W'(2 ** 30);
    localparam logic signed [Z_W-1:0]   Z_HI     = Z_W'(PI_Q13);
    localparam logic signed [Z_W-1:0]   Z_LO     = -Z_W'(PI_Q13);

    // Normalising stages
    logic                    nvld_reg  [NORM_STAGES];
    logic                    nzero_reg [NORM_STAGES];
    logic signed [NUM_W-1:0] nx_reg    [NORM_STAGES];
    logic signed [NUM_W-1:0] ny_reg    [NORM_STAGES];
    // Fold stage
    logic                    ivld_reg, izero_reg;
    logic signed [CX_W-1:0]  ix_reg, iy_reg;
    logic signed [Z_W-1:0]   iz_reg;
    // Rotation stages
    logic                    svld_reg  [STEPS];
    logic                    szero_reg [STEPS];
    logic signed [CX_W-1:0]  sx_reg    [STEPS];
    logic signed [CX_W-1:0]  sy_reg    [STEPS];
    logic signed [Z_W-1:0]   sz_reg    [STEPS];

    angle_t                  ao_reg;

    for (genvar j = 0; j < NORM_STAGES; j++)
    begin : g_norm
        logic                    in_v, in_zero, big;
        logic signed [NUM_W-1:0] in_x, in_y;

        if (j == 0)
        begin : g_first
            assign in_v    = fi.valid;
            assign in_x    = fi.nd;
            assign in_y    = fi.nc;
            assign in_zero = (fi.nc == '0) && (fi.nd == '0);
        end
        else
        begin : g_next
            assign in_v    = nvld_reg[j-1];
            assign in_x    = nx_reg[j-1];
            assign in_y    = ny_reg[j-1];
            assign in_zero = nzero_reg[j-1];
        end

        assign big = (in_x > NORM_LIM) || (in_x < -NORM_LIM)
                  || (in_y > NORM_LIM) || (in_y < -NORM_LIM);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nvld_reg[j] <= 1'b0;
            end
            else
            begin
                nvld_reg[j] <= in_v;
            end
        end

        always_ff @(posedge clk)
        begin
            nzero_reg[j] <= in_zero;
            nx_reg[j]    <= big ? (in_x >>> 1) : in_x;
            ny_reg[j]    <= big ? (in_y >>> 1) : in_y;
        end
    end

    // Fold the left half-plane onto the right
    logic signed [CX_W-1:0] fx, fy;
    assign fx = CX_W'(nx_reg[NORM_STAGES-1]);
    assign fy = CX_W'(ny_reg[NORM_STAGES-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg <= 1'b0;
        end
        else
        begin
            ivld_reg <= nvld_reg[NORM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        izero_reg <= nzero_reg[NORM_STAGES-1];
        if (fx[CX_W-1])
        begin
            ix_reg <= -fx;
            iy_reg <= -fy;
            iz_reg <= fy[CX_W-1] ? -PI_Q16 : PI_Q16;
        end
        else
        begin
            ix_reg <= fx;
            iy_reg <= fy;
            iz_reg <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_rot
        logic                   in_v, in_zero, up;
        logic signed [CX_W-1:0] in_x, in_y, xs, ys;
        logic signed [Z_W-1:0]  in_z;

        if (i == 0)
        begin : g_first
            assign in_v    = ivld_reg;
            assign in_zero = izero_reg;
            assign in_x    = ix_reg;
            assign in_y    = iy_reg;
            assign in_z    = iz_reg;
        end
        else
        begin : g_next
            assign in_v    = svld_reg[i-1];
            assign in_zero = szero_reg[i-1];
            assign in_x    = sx_reg[i-1];
            assign in_y    = sy_reg[i-1];
            assign in_z    = sz_reg[i-1];
        end

        assign xs = in_x >>> i;
        assign ys = in_y >>> i;
        assign up = in_y > 0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                svld_reg[i] <= 1'b0;
            end
            else
            begin
                svld_reg[i] <= in_v;
            end
        end

        always_ff @(posedge clk)
        begin
            szero_reg[i] <= in_zero;
            sx_reg[i]    <= up ? in_x + ys : in_x - ys;
            sy_reg[i]    <= up ? in_y - xs : in_y + xs;
            sz_reg[i]    <= up ? in_z + atan_entry(i) : in_z - atan_entry(i);
        end
    end

    // Round Q.16 to Q2.13 and clamp to plus or minus pi
    logic signed [Z_W-1:0] zr, zc;
    assign zr = (sz_reg[STEPS-1] + Z_W'(4)) >>> 3;

    always_comb
    begin
        priority if (zr > Z_HI)
        begin
            zc = Z_HI;
        end
        else if (zr < Z_LO)
        begin
            zc = Z_LO;
        end
        else
        begin
            zc = zr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ao_reg <= '0;
        end
        else
        begin
            ao_reg.valid <= svld_reg[STEPS-1];
            ao_reg.angle <= szero_reg[STEPS-1] ? '0 : ANG_W'(zc);
        end
    end

    assign ao = ao_reg;

endmodule

>>> src/two_point_planar_pose_solver_core.sv
// Top level of the two-point planar pose solver: configuration, pipeline and result register.

// Solves robot x, y and heading from one rear and one side camera point against two
// configured targets. A transaction is taken on every cycle with start high: busy never
// rises, so a new point pair may follow in the very next cycle. Each result appears on
// the output ports for exactly one cycle, marked by done; the receiver cannot stall it, so
// take it when done is high. The delay to done is set by the CORDIC path: four front-end
// stages, 31 one-bit normalising shifts, one half-plane fold, one stage per CORDIC
// iteration, a rounding stage and the output register. The restoring divider (one
// quotient bit per stage, 33 stages) and the back-substitution run alongside and are
// delayed to line up. Write the target registers only while no transaction is in
// flight. Coinciding camera points give zero pose and angle with degenerate set.
module two_point_planar_pose_solver_core
    import tpps_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [31:0]      side_x,
    input  logic signed [31:0]      side_y,
    input  logic signed [31:0]      rear_x,
    input  logic signed [31:0]      rear_y,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]             cfg_data,
    output logic                    done,
    output logic signed [31:0]      pose_x,
    output logic signed [31:0]      pose_y,
    output logic signed [ANG_W-1:0] pose_angle,
    output logic                    degenerate
);

    // Delay that lines the pose path up with the longer angle path
    localparam int POSE_DLY = CORDIC_STEPS - 2;
    localparam int LATENCY  = 38 + CORDIC_STEPS;

    logic signed [31:0] side_tx_reg, side_ty_reg, rear_tx_reg, rear_ty_reg;

    front_out_t front_q;
    quot_t      quot_q;
    pose_t      pose_q;
    angle_t     angle_q;
    pose_t      dly_reg [POSE_DLY];

    logic                    done_reg, degenerate_reg;
    logic signed [31:0]      pose_x_reg, pose_y_reg;
    logic signed [ANG_W-1:0] pose_angle_reg;

    // No backpressure anywhere: the pipeline advances every cycle
    assign busy = 1'b0;

    // Target registers, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_tx_reg <= '0;
            side_ty_reg <= '0;
            rear_tx_reg <= '0;
            rear_ty_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SIDE_TARGET_X: side_tx_reg <= cfg_data;
                REG_SIDE_TARGET_Y: side_ty_reg <= cfg_data;
                REG_REAR_TARGET_X: rear_tx_reg <= cfg_data;
                REG_REAR_TARGET_Y: rear_ty_reg <= cfg_data;
            endcase
        end
    end

    tpps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .side_x   (side_x),
        .side_y   (side_y),
        .rear_x   (rear_x),
        .rear_y   (rear_y),
        .side_tx  (side_tx_reg),
        .side_ty  (side_ty_reg),
        .rear_tx  (rear_tx_reg),
        .rear_ty  (rear_ty_reg),
        .fo       (front_q)
    );

    // Sine and cosine terms
    tpps_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .fi    (front_q),
        .qo    (quot_q)
    );

    tpps_pose u_pose (
        .clk     (clk),
        .rst_n   (rst_n),
        .qi      (quot_q),
        .rear_tx (rear_tx_reg),
        .rear_ty (rear_ty_reg),
        .po      (pose_q)
    );

    // Heading straight from the numerators, in parallel with the division
    tpps_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .fi    (front_q),
        .ao    (angle_q)
    );

    // Hold the pose until the angle catches up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POSE_DLY; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else
        begin
            dly_reg[0] <= pose_q;
            for (int i = 1; i < POSE_DLY; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dly_reg[POSE_DLY-1].valid;
        end
    end

    // Drop everything to zero for coinciding points
    always_ff @(posedge clk)
    begin
        degenerate_reg <= dly_reg[POSE_DLY-1].degen;
        pose_x_reg     <= dly_reg[POSE_DLY-1].degen ? '0 : dly_reg[POSE_DLY-1].pose_x;
        pose_y_reg     <= dly_reg[POSE_DLY-1].degen ? '0 : dly_reg[POSE_DLY-1].pose_y;
        pose_angle_reg <= dly_reg[POSE_DLY-1].degen ? '0 : angle_q.angle;
    end

    assign done       = done_reg;
    assign pose_x     = pose_x_reg;
    assign pose_y     = pose_y_reg;
    assign pose_angle = pose_angle_reg;
    assign degenerate = degenerate_reg;

`ifndef SYNTHESIS
    // Both paths must deliver the same transaction in the same cycle
    a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        angle_q.valid == dly_reg[POSE_DLY-1].valid)
        else $error("angle and pose paths out of step");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transaction lost in the pipeline");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (pose_x == 0 && pose_y == 0 && pose_angle == 0))
        else $error("degenerate result not zero");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pose_angle <= PI_Q13 && pose_angle >= -PI_Q13))
        else $error("angle outside plus or minus pi");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the two-point planar pose solver core.
`timescale 1ns / 1ps

module tb_top;
    import tpps_pkg::*;

    // Result latency at the default CORDIC depth, plus margin for the drain.
    localparam int LATENCY = 38 + CORDIC_STEPS_DEF;
    localparam int WATCHDOG_LIMIT = 4 * LATENCY + 200;
    localparam int N_RANDOM = 630;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] ang;
        logic               degen;
    } pose_res_t;

    // One row of the directed table: point pair, plus an optional typed-in result.
    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        bit                 known;
        pose_res_t          res;
    } point_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] side_x, side_y, rear_x, rear_y;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic done;
    logic signed [31:0] pose_x, pose_y;
    logic signed [ANG_W-1:0] pose_angle;
    logic degenerate;

    // Predictor's copy of the target registers.
    longint tgt_side_x, tgt_side_y, tgt_rear_x, tgt_rear_y;

    pose_res_t pending_poses[$];
    int mismatches;
    int poses_seen;
    int idle_cycles;
    bit no_idle;

    two_point_planar_pose_solver_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .side_x(side_x), .side_y(side_y), .rear_x(rear_x), .rear_y(rear_y),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .pose_x(pose_x), .pose_y(pose_y),
        .pose_angle(pose_angle), .degenerate(degenerate)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor helpers
    // ---------------------------------------------------------------
    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint trunc_shr(longint v, int n);
        longint m;
        m = (v < 0) ? -v : v;
        m = m >> n;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Smallest shift of 0..2 that brings both magnitudes to 2^30 or below
    function automatic int prescale_shift(longint a, longint b);
        int s;
        s = 0;
        while (s < 2 && ((abs64(a) >> s) > (64'sd1 <<< 30) || (abs64(b) >> s) > (64'sd1 <<< 30)))
            s++;
        return s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // num * 2^k / den toward zero, saturated to +-(2^31-1)
    function automatic longint fixed_quotient(longint num, longint unsigned den, int k);
        longint unsigned m, q, r;
        m = (num < 0) ? longint'(-num) : longint'(num);
        q = m / den;
        r = m % den;
        if (q > (64'd2147483647 >> k))
            q = 64'd2147483647;
        else
            for (int i = 0; i < k; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint heading_atan(longint yv, longint xv);
        longint x, y, z, xs, ys;
        if (xv == 0 && yv == 0) return 0;
        while (abs64(xv) > (64'sd1 <<< 30) || abs64(yv) > (64'sd1 <<< 30)) begin
            xv = xv >>> 1;
            yv = yv >>> 1;
        end
        x = xv;
        y = yv;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_entry(i));
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_entry(i));
            end
        end
        z = (z + 4) >>> 3;
        if (z > longint'(PI_Q13)) z = longint'(PI_Q13);
        if (z < -longint'(PI_Q13)) z = -longint'(PI_Q13);
        return z;
    endfunction

    // Expected pose for one point pair under the current targets
    function automatic pose_res_t solve_pose(longint sx, longint sy, longint rx, longint ry);
        pose_res_t res;
        longint dx, dy, tx, ty, a, b, p, q, nc, nd, c, d;
        longint unsigned den;
        int s, t;
        dx = rx - sx;
        dy = ry - sy;
        tx = tgt_rear_x - tgt_side_x;
        ty = tgt_rear_y - tgt_side_y;
        res.degen = 1'b0;
        if (dx == 0 && dy == 0) begin
            res.px = '0;
            res.py = '0;
            res.ang = '0;
            res.degen = 1'b1;
            return res;
        end
        s = prescale_shift(dx, dy);
        t = prescale_shift(tx, ty);
        a = trunc_shr(dx, s);
        b = trunc_shr(dy, s);
        p = trunc_shr(tx, t);
        q = trunc_shr(ty, t);
        den = longint'(a * a) + longint'(b * b);
        nc = q * a - p * b;
        nd = p * a + q * b;
        c = fixed_quotient(nc, den, 16 + t - s);
        d = fixed_quotient(nd, den, 16 + t - s);
        res.px = 32'(clamp32(tgt_rear_x + floor_shr(c * ry - d * rx, 16)));
        res.py = 32'(clamp32(tgt_rear_y + floor_shr(-c * rx - d * ry, 16)));
        res.ang = 16'(heading_atan(nc, nd));
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Result checking: every done pulse must match the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && done) begin
            pose_res_t want;
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%0d y=%0d ang=%0d deg=%0b",
                             pose_x, pose_y, pose_angle, degenerate);
            end else begin
                want = pending_poses.pop_front();
                poses_seen++;
                if (pose_x !== want.px || pose_y !== want.py ||
                    pose_angle !== want.ang || degenerate !== want.degen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want x=%0d y=%0d ang=%0d deg=%0b, got x=%0d y=%0d ang=%0d deg=%0b",
                                 want.px, want.py, want.ang, want.degen,
                                 pose_x, pose_y, pose_angle, degenerate);
                end
            end
        end
    end

    // Watchdog: count cycles in which no transaction is accepted at either side
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending_poses.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------
    // Hold start low for a random burst now and then
    task automatic maybe_idle();
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drive one point pair and queue its expected pose
    task automatic send_pair(point_row_t row);
        pose_res_t want;
        maybe_idle();
        side_x <= row.sx;
        side_y <= row.sy;
        rear_x <= row.rx;
        rear_y <= row.ry;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        want = solve_pose(row.sx, row.sy, row.rx, row.ry);
        if (row.known && (want.px !== row.res.px || want.py !== row.res.py ||
                          want.ang !== row.res.ang || want.degen !== row.res.degen)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row disagrees with predictor: sx=%0d rx=%0d", row.sx, row.rx);
        end
        pending_poses.push_back(row.known ? row.res : want);
    endtask

    // Let every outstanding result drain, then allow the pipe to settle
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_target(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SIDE_TARGET_X: tgt_side_x = longint'(signed'(val));
            REG_SIDE_TARGET_Y: tgt_side_y = longint'(signed'(val));
            REG_REAR_TARGET_X: tgt_rear_x = longint'(signed'(val));
            default:           tgt_rear_y = longint'(signed'(val));
        endcase
    endtask

    task automatic set_targets(logic [31:0] stx, logic [31:0] sty,
                               logic [31:0] rtx, logic [31:0] rty);
        write_target(REG_SIDE_TARGET_X, stx);
        write_target(REG_SIDE_TARGET_Y, sty);
        write_target(REG_REAR_TARGET_X, rtx);
        write_target(REG_REAR_TARGET_Y, rty);
    endtask

    // Field value: mostly small metre-scale values, sometimes full range
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic point_row_t row_of(logic [31:0] sx, logic [31:0] sy,
                                          logic [31:0] rx, logic [31:0] ry);
        point_row_t row;
        row.sx = sx;
        row.sy = sy;
        row.rx = rx;
        row.ry = ry;
        row.known = 1'b0;
        row.res = '{default: '0};
        return row;
    endfunction

    function automatic point_row_t degenerate_row(logic [31:0] x, logic [31:0] y);
        point_row_t row;
        row = row_of(x, y, x, y);
        row.known = 1'b1;
        row.res = '{px: '0, py: '0, ang: '0, degen: 1'b1};
        return row;
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        point_row_t directed[$];
        point_row_t row;
        int phase_len;
        logic [31:0] px;
        logic [31:0] py;

        rst_n = 1'b0;
        start = 1'b0;
        side_x = '0;
        side_y = '0;
        rear_x = '0;
        rear_y = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        poses_seen = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        tgt_side_x = 0;
        tgt_side_y = 0;
        tgt_rear_x = 0;
        tgt_rear_y = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Targets at reset coincide: pose angle must be zero, pose from rear target
        directed.push_back(row_of(32'h0001_0000, 32'h0, 32'h0, 32'h0));
        directed.push_back(row_of(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        foreach (directed[i]) send_pair(directed[i]);
        drain_pipe();

        // Typical targets, then the directed table: coinciding points, extremes
        set_targets(32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        directed.delete();
        directed.push_back(degenerate_row(32'h0, 32'h0));
        directed.push_back(degenerate_row(32'h7FFF_FFFF, 32'h8000_0000));
        directed.push_back(degenerate_row(32'hFFFF_FFFF, 32'h0000_0001));
        directed.push_back(row_of(32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0));
        directed.push_back(row_of(32'h0, 32'h0, 32'h0000_0001, 32'h0));
        directed.push_back(row_of(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
        directed.push_back(row_of(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0));
        directed.push_back(row_of(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF));
        directed.push_back(row_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        directed.push_back(row_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        directed.push_back(row_of(32'h0002_0000, 32'h0, 32'hFFFE_0000, 32'h0));
        directed.push_back(row_of(32'h0, 32'h0002_0000, 32'h0, 32'hFFFE_0000));
        directed.push_back(row_of(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555));
        foreach (directed[i]) send_pair(directed[i]);
        drain_pipe();

        // Extreme targets: drive the quotient and pose into saturation
        set_targets(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        directed.delete();
        directed.push_back(row_of(32'h0, 32'h0, 32'h0000_0001, 32'h0));
        directed.push_back(row_of(32'h0, 32'h0, 32'h0, 32'h0000_0001));
        directed.push_back(row_of(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0));
        directed.push_back(row_of(32'h1234_5678, 32'h8765_4321, 32'h0000_0003, 32'hFFFF_FFFD));
        directed.push_back(degenerate_row(32'h8000_0000, 32'h8000_0000));
        foreach (directed[i]) send_pair(directed[i]);
        drain_pipe();

        // Random phases, each under fresh targets; the last phase runs back to back
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5)
                no_idle = 1'b1;
            set_targets(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            phase_len = N_RANDOM / 6;
            for (int n = 0; n < phase_len; n++) begin
                if ($urandom_range(0, 19) == 0) begin
                    px = rand_coord();
                    py = rand_coord();
                    row = row_of(px, py, px, py);
                end else
                    row = row_of(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                send_pair(row);
            end
            drain_pipe();
        end

        $display("covered %0d poses over reset, extreme and random target settings",
                 poses_seen);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> files.f
src/tpps_pkg.sv
src/tpps_front.sv
src/tpps_divider.sv
src/tpps_pose.sv
src/tpps_cordic.sv
src/two_point_planar_pose_solver_core.sv
bench/tb_top.sv
